// ----- hdl/knn_pkg.sv -----
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types, widths and constants of the nearest-neighbor list store.
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int IDX_W  = 10;
    localparam int DIST_W = 32;

    localparam int NODES_DEF     = 1024;
    localparam int NEIGHBORS_DEF = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // one list position as kept in the store
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
        logic              fresh;
    } t_entry;

    localparam t_entry ENTRY_CLEAR = '{
        valid: 1'b0, idx: '0, distance: DIST_MAX, fresh: 1'b0
    };

    // outcome of comparing one stored entry with the candidate
    typedef struct packed {
        logic dup;
        logic le;
    } t_cmp;

endpackage

// ----- hdl/knn_if.sv -----
// ----------------------------------------------------------------------------
// knn request and response channels
// Valid/ready channels carrying the list commands and their results.
// ----------------------------------------------------------------------------
interface knn_req_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [knn_pkg::IDX_W-1:0]  node_index;
    logic [knn_pkg::IDX_W-1:0]  neighbor_index;
    logic [knn_pkg::DIST_W-1:0] neighbor_distance;
    logic                       neighbor_new;

    modport source (
        output valid, command, node_index, neighbor_index, neighbor_distance, neighbor_new,
        input  ready
    );
    modport sink (
        input  valid, command, node_index, neighbor_index, neighbor_distance, neighbor_new,
        output ready
    );
endinterface

interface knn_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic [knn_pkg::IDX_W-1:0]  entry_index;
    logic [knn_pkg::DIST_W-1:0] entry_distance;
    logic                       entry_new;
    logic                       entry_valid;
    logic                       last;

    modport source (
        output valid, accepted, entry_index, entry_distance, entry_new, entry_valid, last,
        input  ready
    );
    modport sink (
        input  valid, accepted, entry_index, entry_distance, entry_new, entry_valid, last,
        output ready
    );
endinterface

// ----- hdl/knn_cmp.sv -----
// ----------------------------------------------------------------------------
// knn_cmp
// Compare unit: duplicate check and distance order of one entry.
// ----------------------------------------------------------------------------
module knn_cmp (
    input  knn_pkg::t_entry            i_entry,
    input  logic [knn_pkg::IDX_W-1:0]  i_cand_idx,
    input  logic [knn_pkg::DIST_W-1:0] i_cand_dist,
    output knn_pkg::t_cmp              o_res
);

    // invalid positions never count as duplicates
    assign o_res.dup = i_entry.valid && (i_entry.idx == i_cand_idx);
    assign o_res.le  = (i_entry.distance <= i_cand_dist);

endmodule

// ----- hdl/knn_store.sv -----
// ----------------------------------------------------------------------------
// knn_store
// Neighbor entry memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module knn_store #(
    parameter int AW = 14
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  knn_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output knn_pkg::t_entry o_rdata
);

    localparam int DEPTH = 1 << AW;

    knn_pkg::t_entry r_mem [DEPTH];
    knn_pkg::t_entry r_rdata;

    // a read of the address being written returns the old entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/knn_list_insert.sv -----
// ----------------------------------------------------------------------------
// knn_list_insert
// Per-node sorted list of nearest neighbors with insert and read requests.
// ----------------------------------------------------------------------------
// Insert: a scan of the node's list, a shift of the entries from the insert
//   position one place down, a write of the candidate and a result; a rejected request skips shift and write.
// Read: each list position is issued, waited for and returned in turn.
// One request at a time; the response side may hold off each result.
// Reset: a clearing pass writes every store address; no request is taken
//   meanwhile.
module knn_list_insert #(
    parameter int NODES     = knn_pkg::NODES_DEF,
    parameter int NEIGHBORS = knn_pkg::NEIGHBORS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    knn_req_if.sink   i_req,
    knn_rsp_if.source o_rsp
);

    localparam int RW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int CW = $clog2(NEIGHBORS + 1);
    localparam int AW = RW + SW;

    localparam logic [CW-1:0] K_CNT   = CW'(NEIGHBORS);
    localparam logic [CW-1:0] K_LAST  = CW'(NEIGHBORS - 1);
    localparam logic [SW-1:0] S_LAST  = SW'(NEIGHBORS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_RESULT,
        S_RD_ISSUE,
        S_RD_WAIT
    } t_state;

    t_state r_state;

    logic [AW-1:0]               r_clr;
    logic [RW-1:0]               r_row;
    logic                        r_node_ok;
    logic [knn_pkg::IDX_W-1:0]   r_nb;
    logic [knn_pkg::DIST_W-1:0]  r_dist;
    logic                        r_new;
    logic [CW-1:0]               r_k;
    logic [CW-1:0]               r_pos;
    logic                        r_dup;
    logic                        r_acc;
    logic                        r_rd_pend;
    logic [SW-1:0]               r_rd_slot;

    logic                        r_out_vld;
    knn_pkg::t_entry             r_out_entry;
    logic                        r_out_acc;
    logic                        r_out_last;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    knn_pkg::t_entry w_wdata;
    logic            w_re;
    logic [AW-1:0]   w_raddr;
    knn_pkg::t_entry w_rdata;
    knn_pkg::t_cmp   w_cmp;
    knn_pkg::t_entry w_cand;

    logic          w_out_free;
    logic          w_req_acc;
    logic          w_node_ok;
    logic          w_nb_ok;
    logic          w_dup_next;
    logic [CW-1:0] w_pos_next;
    logic          w_shift_issue;

    knn_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    knn_cmp u_cmp (
        .i_entry     (w_rdata),
        .i_cand_idx  (r_nb),
        .i_cand_dist (r_dist),
        .o_res       (w_cmp)
    );

    assign w_out_free = !r_out_vld || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_acc  = i_req.valid && i_req.ready;
    assign w_node_ok  = (32'(i_req.node_index) < NODES);
    assign w_nb_ok    = (32'(i_req.neighbor_index) < NODES);

    assign w_dup_next    = r_dup || w_cmp.dup;
    assign w_pos_next    = r_pos + CW'(w_cmp.le);
    assign w_shift_issue = (r_state == S_SHIFT) && (r_k < K_LAST);

    assign w_cand = '{valid: 1'b1, idx: r_nb, distance: r_dist, fresh: r_new};

    // store port steering
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = knn_pkg::ENTRY_CLEAR;
        w_re    = 1'b0;
        w_raddr = {r_row, r_k[SW-1:0]};
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_SCAN: begin
                w_re = (r_k < K_CNT);
            end
            S_SHIFT: begin
                // move the entry read last cycle one place down the list
                w_re    = w_shift_issue;
                w_we    = r_rd_pend;
                w_waddr = {r_row, SW'(r_rd_slot + 1'b1)};
                w_wdata = w_rdata;
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = {r_row, r_pos[SW-1:0]};
                w_wdata = w_cand;
            end
            S_RD_ISSUE: begin
                w_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_pos     <= '0;
            r_rd_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_req_acc) begin
                        r_row     <= RW'(i_req.node_index);
                        r_node_ok <= w_node_ok;
                        r_nb      <= i_req.neighbor_index;
                        r_dist    <= i_req.neighbor_distance;
                        r_new     <= i_req.neighbor_new;
                        r_k       <= '0;
                        r_pos     <= '0;
                        r_dup     <= 1'b0;
                        r_rd_pend <= 1'b0;
                        if (i_req.command == knn_pkg::CMD_READ) begin
                            r_state <= S_RD_ISSUE;
                        end else if (w_node_ok && w_nb_ok) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_acc   <= 1'b0;
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= (r_k < K_CNT);
                    r_rd_slot <= r_k[SW-1:0];
                    if (r_k < K_CNT) begin
                        r_k <= r_k + 1'b1;
                    end
                    if (r_rd_pend) begin
                        r_dup <= w_dup_next;
                        r_pos <= w_pos_next;
                        if (r_rd_slot == S_LAST) begin
                            // the list is full of closer or equal entries when pos reaches K
                            if (!w_dup_next && (w_pos_next < K_CNT)) begin
                                r_k       <= w_pos_next;
                                r_rd_pend <= 1'b0;
                                r_state   <= S_SHIFT;
                            end else begin
                                r_acc   <= 1'b0;
                                r_state <= S_RESULT;
                            end
                        end
                    end
                end
                S_SHIFT: begin
                    r_rd_pend <= w_shift_issue;
                    r_rd_slot <= r_k[SW-1:0];
                    if (w_shift_issue) begin
                        r_k <= r_k + 1'b1;
                    end else if (!r_rd_pend) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    r_acc   <= 1'b1;
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_vld   <= 1'b1;
                        r_out_acc   <= r_acc;
                        r_out_entry <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_RD_ISSUE: begin
                    r_state <= S_RD_WAIT;
                end
                S_RD_WAIT: begin
                    if (w_out_free) begin
                        r_out_vld   <= 1'b1;
                        r_out_acc   <= 1'b0;
                        r_out_entry <= r_node_ok ? w_rdata : knn_pkg::ENTRY_CLEAR;
                        r_out_last  <= (r_k == K_LAST);
                        if (r_k == K_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_RD_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.accepted       = r_out_acc;
    assign o_rsp.entry_index    = r_out_entry.idx;
    assign o_rsp.entry_distance = r_out_entry.distance;
    assign o_rsp.entry_new      = r_out_entry.fresh;
    assign o_rsp.entry_valid    = r_out_entry.valid;
    assign o_rsp.last           = r_out_last;

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= K_CNT)
        else $error("insert position beyond list length");

    a_pend_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && (r_state == S_SCAN || r_state == S_SHIFT)) |-> $past(w_re))
        else $error("pending read data without a read issued");

    a_shift_below_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && w_we) |-> (32'(r_rd_slot) >= 32'(r_pos)))
        else $error("shift writes above the insert position");

    a_insert_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && w_out_free) |=> (r_out_vld && r_out_last))
        else $error("insert result not marked last");

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !w_req_acc)
        else $error("request taken during clearing pass");
`endif

endmodule
